FILE: sv/ssmd_pkg.sv
package ssmd_pkg;

   localparam int DigitCountDefault = 4;
   localparam int WordBits          = 16;
   localparam int BitNumBits        = 4;

   typedef logic [2:0]          op_type;
   typedef logic [7:0]          pattern_type;
   typedef logic [WordBits-1:0] word_type;

   localparam op_type OP_REFRESH = 3'd0;
   localparam op_type OP_STORE   = 3'd1;
   localparam op_type OP_CHAR    = 3'd2;
   localparam op_type OP_DECIMAL = 3'd3;
   localparam op_type OP_BYTE    = 3'd4;
   localparam op_type OP_GAUGE   = 3'd5;
   localparam op_type OP_CLEAR   = 3'd6;

   localparam pattern_type RESET_PATTERN   = 8'h20;
   localparam pattern_type UNKNOWN_PATTERN = 8'd182;
   localparam pattern_type BLANK_PATTERN   = 8'hFF;
   localparam pattern_type SEL_BASE        = 8'h10;

   // load request handed to the serializer
   typedef struct packed {
      logic     load;
      word_type word;
   } ser_load_type;

   function automatic pattern_type num_glyph(input logic [3:0] n);
      pattern_type g;
      case (n)
         4'd0:    g = 8'hFC;
         4'd1:    g = 8'h60;
         4'd2:    g = 8'hDA;
         4'd3:    g = 8'hF2;
         4'd4:    g = 8'h66;
         4'd5:    g = 8'hB6;
         4'd6:    g = 8'h3E;
         4'd7:    g = 8'hE0;
         4'd8:    g = 8'hFE;
         4'd9:    g = 8'hE6;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   function automatic pattern_type alpha_glyph(input logic [4:0] n);
      pattern_type g;
      case (n)
         5'd0:    g = 8'hEE;
         5'd1:    g = 8'hFE;
         5'd2:    g = 8'h9C;
         5'd3:    g = 8'hFC;
         5'd4:    g = 8'h9E;
         5'd5:    g = 8'h8E;
         5'd6:    g = 8'hBE;
         5'd7:    g = 8'h6E;
         5'd8:    g = 8'h0C;
         5'd9:    g = 8'h78;
         5'd10:   g = 8'h00;
         5'd11:   g = 8'h1C;
         5'd12:   g = 8'hEC;
         5'd13:   g = 8'h2E;
         5'd14:   g = 8'h3A;
         5'd15:   g = 8'hCE;
         5'd16:   g = 8'h3B;
         5'd17:   g = 8'hEE;
         5'd18:   g = 8'hB6;
         5'd19:   g = 8'h0E;
         5'd20:   g = 8'h7C;
         5'd21:   g = 8'h38;
         5'd22:   g = 8'h38;
         5'd23:   g = 8'h00;
         5'd24:   g = 8'h66;
         5'd25:   g = 8'hDA;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   function automatic pattern_type char_pattern(input logic [7:0] c);
      pattern_type p;
      logic [7:0]  off_num;
      logic [7:0]  off_low;
      logic [7:0]  off_up;
      off_num = c - 8'd48;
      off_low = c - 8'd97;
      off_up  = c - 8'd65;
      if (c inside {[8'd48:8'd57]})       p = ~num_glyph(off_num[3:0]);
      else if (c inside {[8'd97:8'd122]}) p = ~alpha_glyph(off_low[4:0]);
      else if (c inside {[8'd65:8'd90]})  p = ~alpha_glyph(off_up[4:0]);
      else if (c == 8'd45)                p = ~8'h02;
      else if (c == 8'd46)                p = ~8'h01;
      else if (c == 8'd95)                p = ~8'h10;
      else if (c == 8'd32)                p = BLANK_PATTERN;
      else                                p = UNKNOWN_PATTERN;
      return p;
   endfunction

   function automatic pattern_type gauge_pattern(input logic [7:0] v);
      pattern_type bar;
      if (v >= 8'd100)     bar = 8'hFC;
      else if (v >= 8'd85) bar = 8'h7C;
      else if (v >= 8'd68) bar = 8'h78;
      else if (v >= 8'd51) bar = 8'h70;
      else if (v >= 8'd35) bar = 8'h60;
      else if (v >= 8'd17) bar = 8'h40;
      else                 bar = 8'h00;
      return ~bar;
   endfunction

endpackage

FILE: sv/seven_segment_mux_serial_driver.sv
// channel   ports                                       direction
// req       req_valid req_stall req_op                  in (stall out)
//           req_digit_index req_value
// rsp       rsp_valid rsp_stall rsp_serial_bit          out (stall in)
//           rsp_bit_number rsp_latch_after
//
// a write, refresh or clear transaction gives 16 results, one per cycle while rsp
// does not stall, counted out by the serializer's bit counter; store raw and op
// seven retire without waiting for the serializer and give nothing
// the next transaction is held in the input register while a word shifts out
// reset is synchronous: patterns go to 0x20, scan pointer to zero, no word pending
// a stall on rsp holds the current bit; req stalls only while the input register
// waits for the serializer
module seven_segment_mux_serial_driver
   import ssmd_pkg::*;
#(
   parameter int DIGIT_COUNT = DigitCountDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_op,
   input  logic [1:0]            req_digit_index,
   input  logic [7:0]            req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_serial_bit,
   output logic [BitNumBits-1:0] rsp_bit_number,
   output logic                  rsp_latch_after
);

   localparam logic [1:0] LastDigit = 2'(DIGIT_COUNT - 1);

   logic        valid_ff, valid_in;
   op_type      op_ff, op_in;
   logic [1:0]  digit_ff, digit_in;
   logic [7:0]  value_ff, value_in;

   pattern_type patterns_ff [4];
   logic [1:0]  scan_ff, scan_in;

   pattern_type  new_pattern;
   logic         has_word;
   logic         writes_pattern;
   logic         advance;
   logic         can_load;
   ser_load_type load_req;
   logic [1:0]   sel_digit;
   pattern_type  sel_pattern;

   ssmd_encoder u_encoder (
      .op      (op_ff),
      .value   (value_ff),
      .pattern (new_pattern)
   );

   always_comb begin
      has_word       = 1'b0;
      writes_pattern = 1'b0;
      case (op_ff)
         OP_REFRESH: has_word = 1'b1;
         OP_STORE:   writes_pattern = 1'b1;
         OP_CHAR, OP_DECIMAL, OP_BYTE, OP_GAUGE: begin
            has_word       = 1'b1;
            writes_pattern = 1'b1;
         end
         OP_CLEAR:   has_word = 1'b1;
         default:    has_word = 1'b0;
      endcase
   end

   assign advance   = valid_ff && (!has_word || can_load);
   assign req_stall = valid_ff && !advance;

   always_comb begin
      if (op_ff == OP_REFRESH) begin
         sel_digit   = scan_ff;
         sel_pattern = patterns_ff[scan_ff];
      end else begin
         sel_digit   = digit_ff;
         sel_pattern = new_pattern;
      end
      load_req.load = advance && has_word;
      if (op_ff == OP_CLEAR) load_req.word = '0;
      else                   load_req.word = {SEL_BASE << sel_digit, sel_pattern};
   end

   always_comb begin
      valid_in = valid_ff;
      op_in    = op_ff;
      digit_in = digit_ff;
      value_in = value_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         op_in    = req_op;
         digit_in = req_digit_index;
         value_in = req_value;
      end
      scan_in = scan_ff;
      if (advance && op_ff == OP_REFRESH)
         scan_in = (scan_ff >= LastDigit) ? 2'd0 : scan_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         scan_ff  <= '0;
         for (int i = 0; i < 4; i++) patterns_ff[i] <= RESET_PATTERN;
      end else begin
         valid_ff <= valid_in;
         scan_ff  <= scan_in;
         if (advance && writes_pattern) patterns_ff[digit_ff] <= new_pattern;
      end
      op_ff    <= op_in;
      digit_ff <= digit_in;
      value_ff <= value_in;
   end

   ssmd_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load_req        (load_req),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_bit_number  (rsp_bit_number),
      .rsp_latch_after (rsp_latch_after)
   );

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= LastDigit)
      else $error("scan pointer beyond last digit");

   a_no_word_for_store: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && op_ff == OP_STORE) |-> (advance && !load_req.load))
      else $error("store raw must retire at once without a word");

   a_refresh_steps_scan: assert property (@(posedge clock) disable iff (reset)
      (advance && op_ff == OP_REFRESH && scan_ff != LastDigit) |=>
         scan_ff == $past(scan_ff) + 2'd1)
      else $error("refresh did not step the scan pointer");

endmodule

FILE: sv/ssmd_encoder.sv
module ssmd_encoder
   import ssmd_pkg::*;
(
   input  op_type      op,
   input  logic [7:0]  value,
   output pattern_type pattern
);

   logic [3:0] dec_clamped;

   assign dec_clamped = (value > 8'd9) ? 4'd9 : value[3:0];

   always_comb begin
      case (op)
         OP_CHAR:    pattern = char_pattern(value);
         OP_DECIMAL: pattern = ~num_glyph(dec_clamped);
         OP_GAUGE:   pattern = gauge_pattern(value);
         default:    pattern = value;
      endcase
   end

endmodule

FILE: sv/ssmd_serializer.sv
module ssmd_serializer
   import ssmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ser_load_type          load_req,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_serial_bit,
   output logic [BitNumBits-1:0] rsp_bit_number,
   output logic                  rsp_latch_after
);

   localparam logic [BitNumBits-1:0] LastBit = BitNumBits'(WordBits - 1);

   logic                  busy_ff, busy_in;
   logic [BitNumBits-1:0] count_ff, count_in;
   word_type              word_ff, word_in;
   logic                  taken;
   logic                  last_taken;

   assign taken      = busy_ff && !rsp_stall;
   assign last_taken = taken && (count_ff == LastBit);
   assign can_load   = !busy_ff || last_taken;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      word_in  = word_ff;
      if (load_req.load) begin
         busy_in  = 1'b1;
         count_in = '0;
         word_in  = load_req.word;
      end else if (last_taken) begin
         busy_in = 1'b0;
      end else if (taken) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid       = busy_ff;
   assign rsp_serial_bit  = word_ff[count_ff];
   assign rsp_bit_number  = count_ff;
   assign rsp_latch_after = (count_ff == LastBit);

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_req.load |-> (!busy_ff || last_taken))
      else $error("serializer loaded while a word is still going out");

   a_load_starts_word: assert property (@(posedge clock) disable iff (reset)
      load_req.load |=> (busy_ff && count_ff == '0))
      else $error("load did not restart at bit zero");

   a_bit_advance: assert property (@(posedge clock) disable iff (reset)
      (taken && count_ff != LastBit && !load_req.load) |=>
         (busy_ff && count_ff == $past(count_ff) + 1'b1))
      else $error("bit counter failed to advance");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_stall) |=> (busy_ff && $stable(count_ff)))
      else $error("bit position moved while stalled");

endmodule
